// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is ignored while reset is high.
`define ASSERT_RST(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("assertion failed");

// Concurrent assertion that is checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) else $error("assertion failed");

`endif

// ----- design/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// Round robin scheduler package
// Types, sizes and codes shared by the scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;

  localparam int MAX_THREADS = 16;
  localparam int SLOT_W = $clog2(MAX_THREADS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);

  localparam logic [2:0] ACT_TICK = 3'd0;
  localparam logic [2:0] ACT_CREATE = 3'd1;
  localparam logic [2:0] ACT_EXIT = 3'd2;
  localparam logic [2:0] ACT_BLOCK = 3'd3;
  localparam logic [2:0] ACT_UNBLOCK = 3'd4;
  localparam logic [2:0] ACT_SLEEP = 3'd5;

  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] thread_id;
    logic [15:0] sleep_count;
  } in_item_t;

  typedef struct packed {
    logic status;
    logic [3:0] new_thread;
    logic [3:0] running_thread;
    logic switched;
    logic cpu_idle;
    logic all_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0] st;
    logic [15:0] sleep;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic re;
    logic [SLOT_W-1:0] raddr;
    logic we;
    logic [SLOT_W-1:0] waddr;
    slot_entry_t wdata;
  } slot_req_t;

  typedef struct packed {
    logic re;
    logic [SLOT_W-1:0] raddr;
    logic we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
  } ring_req_t;

endpackage
`default_nettype wire

// ----- design/rrts_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/rrts_ctrl.sv -----
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Walks the slot table and ready ring held in RAM, at most one access to each RAM at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rrts_ctrl import rrts_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire in_item_t          in_item,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      out_item_t         out_item,
  output      slot_req_t         slot_req,
  input  wire slot_entry_t       slot_rdata,
  output      ring_req_t         ring_req,
  input  wire logic [SLOT_W-1:0] ring_rdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_BK_EX, S_UB_EX, S_TK_RD, S_TK_EX, S_CR_RD, S_CR_EX,
    S_PK_RD, S_PK_RS, S_PK_EX, S_NF_EX, S_FIN
  } state_t;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_THREADS);
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(MAX_THREADS - 1);

  state_t state, state_next;
  logic [MAX_THREADS-1:0] valid, valid_next, seen, seen_next;
  logic [SLOT_W-1:0] cur, cur_next, head, head_next, tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic out_valid_next;
  logic [2:0] act, act_next;
  logic [3:0] tid, tid_next;
  logic [15:0] cnt, cnt_next;
  logic [SLOT_W-1:0] idx, idx_next, cand, cand_next;
  logic mode_exit, mode_exit_next;
  logic status, status_next, switched, switched_next;
  logic idle, idle_next, done, done_next;
  logic [SLOT_W-1:0] created, created_next;
  out_item_t out_item_next;
  logic [SLOT_W-1:0] rd_addr;
  logic rd_seen;
  slot_entry_t rd_entry;
  logic push_en;
  logic [SLOT_W-1:0] push_slot, t, free_slot;
  logic free_found, ok_id, bad_id;
  logic [15:0] dec;

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] x);
    return (x == LAST) ? '0 : x + 1'b1;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign t = SLOT_W'(tid);
  assign ok_id = (32'(tid) < MAX_THREADS) && valid[t];
  assign bad_id = (tid == 4'd0) || !ok_id;
  assign dec = rd_entry.sleep - 16'd1;

  always_comb begin
    rd_entry = slot_rdata;
    if (!rd_seen) begin
      rd_entry.st = (rd_addr == '0) ? ST_RUNNING : ST_READY;
      rd_entry.sleep = '0;
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_slot = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    valid_next = valid;
    seen_next = seen;
    cur_next = cur;
    head_next = head;
    tail_next = tail;
    count_next = count;
    out_valid_next = out_valid && !out_ready;
    out_item_next = out_item;
    act_next = act;
    tid_next = tid;
    cnt_next = cnt;
    idx_next = idx;
    cand_next = cand;
    mode_exit_next = mode_exit;
    status_next = status;
    switched_next = switched;
    idle_next = idle;
    done_next = done;
    created_next = created;
    slot_req = '0;
    ring_req = '0;
    push_en = 1'b0;
    push_slot = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          act_next = in_item.action;
          tid_next = in_item.thread_id;
          cnt_next = in_item.sleep_count;
          status_next = 1'b0;
          switched_next = 1'b0;
          idle_next = 1'b0;
          done_next = 1'b0;
          created_next = '0;
          mode_exit_next = 1'b0;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_FIN;
        idx_next = '0;
        case (act)
          ACT_TICK: state_next = S_TK_RD;
          ACT_CREATE: begin
            if (free_found) begin
              valid_next[free_slot] = 1'b1;
              slot_req.we = 1'b1;
              slot_req.waddr = free_slot;
              slot_req.wdata = '{st: ST_READY, sleep: '0};
              push_en = 1'b1;
              push_slot = free_slot;
              created_next = free_slot;
            end else begin
              status_next = 1'b1;
            end
          end
          ACT_EXIT: begin
            if (bad_id) begin
              status_next = 1'b1;
            end else begin
              valid_next[t] = 1'b0;
              slot_req.we = 1'b1;
              slot_req.waddr = t;
              slot_req.wdata = '{st: ST_BLOCKED, sleep: '0};
              if (t == cur) begin
                mode_exit_next = 1'b1;
                state_next = S_PK_RD;
              end
            end
          end
          ACT_BLOCK: begin
            if (bad_id) begin
              status_next = 1'b1;
            end else begin
              slot_req.re = 1'b1;
              slot_req.raddr = t;
              state_next = S_BK_EX;
            end
          end
          ACT_UNBLOCK: begin
            if (!ok_id) begin
              status_next = 1'b1;
            end else begin
              slot_req.re = 1'b1;
              slot_req.raddr = t;
              state_next = S_UB_EX;
            end
          end
          ACT_SLEEP: begin
            if (cnt == 16'd0 || cur == '0) begin
              status_next = 1'b1;
            end else begin
              slot_req.we = 1'b1;
              slot_req.waddr = cur;
              slot_req.wdata = '{st: ST_BLOCKED, sleep: cnt};
              state_next = S_TK_RD;
            end
          end
          default: status_next = 1'b1;
        endcase
      end
      S_BK_EX: begin
        state_next = S_FIN;
        if (rd_entry.st != ST_BLOCKED) begin
          slot_req.we = 1'b1;
          slot_req.waddr = t;
          slot_req.wdata = '{st: ST_BLOCKED, sleep: rd_entry.sleep};
          if (t == cur) begin
            idx_next = '0;
            state_next = S_TK_RD;
          end
        end
      end
      S_UB_EX: begin
        state_next = S_FIN;
        if (rd_entry.st == ST_BLOCKED) begin
          slot_req.we = 1'b1;
          slot_req.waddr = t;
          slot_req.wdata = '{st: ST_READY, sleep: rd_entry.sleep};
          push_en = 1'b1;
          push_slot = t;
        end
      end
      S_TK_RD: begin
        slot_req.re = 1'b1;
        slot_req.raddr = idx;
        state_next = S_TK_EX;
      end
      S_TK_EX: begin
        if (valid[idx] && rd_entry.st == ST_BLOCKED && rd_entry.sleep != 16'd0) begin
          slot_req.we = 1'b1;
          slot_req.waddr = idx;
          slot_req.wdata = '{st: (dec == 16'd0) ? ST_READY : ST_BLOCKED, sleep: dec};
          if (dec == 16'd0) begin
            push_en = 1'b1;
            push_slot = idx;
          end
        end
        if (idx == LAST) begin
          state_next = S_CR_RD;
        end else begin
          idx_next = idx + 1'b1;
          state_next = S_TK_RD;
        end
      end
      S_CR_RD: begin
        slot_req.re = 1'b1;
        slot_req.raddr = cur;
        state_next = S_CR_EX;
      end
      S_CR_EX: begin
        if (valid[cur] && rd_entry.st == ST_RUNNING) begin
          slot_req.we = 1'b1;
          slot_req.waddr = cur;
          slot_req.wdata = '{st: ST_READY, sleep: rd_entry.sleep};
          push_en = 1'b1;
          push_slot = cur;
        end
        state_next = S_PK_RD;
      end
      S_PK_RD: begin
        if (count == '0) begin
          if (mode_exit) begin
            done_next = 1'b1;
            state_next = S_FIN;
          end else begin
            slot_req.re = 1'b1;
            slot_req.raddr = cur;
            state_next = S_NF_EX;
          end
        end else begin
          ring_req.re = 1'b1;
          ring_req.raddr = head;
          head_next = wrap_inc(head);
          count_next = count - 1'b1;
          state_next = S_PK_RS;
        end
      end
      S_PK_RS: begin
        cand_next = ring_rdata;
        slot_req.re = 1'b1;
        slot_req.raddr = ring_rdata;
        state_next = S_PK_EX;
      end
      S_PK_EX: begin
        if (valid[cand] && rd_entry.st == ST_READY) begin
          slot_req.we = 1'b1;
          slot_req.waddr = cand;
          slot_req.wdata = '{st: ST_RUNNING, sleep: rd_entry.sleep};
          switched_next = mode_exit || (cand != cur);
          cur_next = cand;
          state_next = S_FIN;
        end else begin
          state_next = S_PK_RD;
        end
      end
      S_NF_EX: begin
        if (rd_entry.st != ST_BLOCKED) begin
          slot_req.we = 1'b1;
          slot_req.waddr = cur;
          slot_req.wdata = '{st: ST_RUNNING, sleep: rd_entry.sleep};
        end else begin
          idle_next = 1'b1;
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_item_next = '{status: status, new_thread: 4'(created),
                            running_thread: 4'(cur), switched: switched,
                            cpu_idle: idle, all_done: done};
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (push_en && count < FULL) begin
      ring_req.we = 1'b1;
      ring_req.waddr = tail;
      ring_req.wdata = push_slot;
      tail_next = wrap_inc(tail);
      count_next = count + 1'b1;
    end
    if (slot_req.we) begin
      seen_next[slot_req.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= MAX_THREADS'(1);
      seen <= '0;
      cur <= '0;
      head <= '0;
      tail <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      seen <= seen_next;
      cur <= cur_next;
      head <= head_next;
      tail <= tail_next;
      count <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_item <= out_item_next;
    act <= act_next;
    tid <= tid_next;
    cnt <= cnt_next;
    idx <= idx_next;
    cand <= cand_next;
    mode_exit <= mode_exit_next;
    status <= status_next;
    switched <= switched_next;
    idle <= idle_next;
    done <= done_next;
    created <= created_next;
    if (slot_req.re) begin
      rd_addr <= slot_req.raddr;
      rd_seen <= seen[slot_req.raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/round_robin_thread_scheduler.sv -----
// A tick or sleep is dispatched, then reads and updates each slot in a countdown pass,
// reads and requeues the running slot, pops ring entries until a ready one is found and
// hands over the result; a block of the running slot updates that slot, then takes this path.
// Other events take fewer steps, an exit of the running slot also popping ring entries.
// One item is in work at a time; the next is taken while a result waits.
// Synchronous reset leaves slot 0 running and the ring empty; no clearing pass.
// ----------------------------------------------------------------------------
// Round robin thread scheduler
// Top level joining the sequencer to the slot table and ready ring RAMs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module round_robin_thread_scheduler import rrts_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_item,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_item
);

  slot_req_t slot_req;
  ring_req_t ring_req;
  logic [ENTRY_W-1:0] slot_rdata;
  logic [SLOT_W-1:0] ring_rdata;

  rrts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .slot_req   (slot_req),
    .slot_rdata (slot_entry_t'(slot_rdata)),
    .ring_req   (ring_req),
    .ring_rdata (ring_rdata)
  );

  rrts_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_THREADS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_req.we),
    .waddr (slot_req.waddr),
    .wdata (slot_req.wdata),
    .re    (slot_req.re),
    .raddr (slot_req.raddr),
    .rdata (slot_rdata)
  );

  rrts_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_THREADS)) u_ring_ram (
    .clk   (clk),
    .we    (ring_req.we),
    .waddr (ring_req.waddr),
    .wdata (ring_req.wdata),
    .re    (ring_req.re),
    .raddr (ring_req.raddr),
    .rdata (ring_rdata)
  );

endmodule
`default_nettype wire

// ----- design/rrts_checker.sv -----
// ----------------------------------------------------------------------------
// Scheduler port checker
// Checks result items seen on the top level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rrts_checker import rrts_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  `ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_item))
  `ASSERT_RST(a_done_no_switch, clk, rst, out_valid && out_item.all_done |-> !out_item.switched && !out_item.status)
  `ASSERT_RST(a_idle_no_switch, clk, rst, out_valid && out_item.cpu_idle |-> !out_item.switched && !out_item.all_done)
  `ASSERT_RST(a_create_ok, clk, rst, out_valid && out_item.new_thread != 4'd0 |-> !out_item.status)

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Round robin scheduler testbench
// Drives scheduler events through the valid/ready input, predicts each result
// from a behavioural copy of the slot table and ready queue, and compares
// every result field by field. A directed table comes first, then random
// event sequences. Input bursts and output stalls are random, with one long
// output hold-off so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import rrts_pkg::*;

  localparam int N_RANDOM = 530;
  localparam logic [2:0] ACT_BAD6 = 3'd6;
  localparam logic [2:0] ACT_BAD7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  round_robin_thread_scheduler dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  // Scheduler shadow state.
  logic        sh_valid [MAX_THREADS];
  logic [1:0]  sh_state [MAX_THREADS];
  logic [15:0] sh_sleep [MAX_THREADS];
  logic [3:0]  sh_ring [MAX_THREADS];
  logic [3:0]  sh_head, sh_tail, sh_cur;
  int          sh_count;

  out_item_t pending_results[$];
  int errors = 0;
  int n_results = 0;
  int n_switch = 0;
  int n_idle = 0;
  int n_done = 0;
  bit hold_off_done = 1'b0;

  function automatic void sched_reset();
    for (int i = 0; i < MAX_THREADS; i++) begin
      sh_valid[i] = 1'b0;
      sh_state[i] = ST_READY;
      sh_sleep[i] = '0;
      sh_ring[i] = '0;
    end
    sh_valid[0] = 1'b1;
    sh_state[0] = ST_RUNNING;
    sh_head = '0;
    sh_tail = '0;
    sh_cur = '0;
    sh_count = 0;
  endfunction

  function automatic void ring_push(logic [3:0] s);
    if (sh_count >= MAX_THREADS) return;
    sh_ring[sh_tail] = s;
    sh_tail = sh_tail + 4'd1;
    sh_count++;
  endfunction

  function automatic bit ring_pick(output logic [3:0] nxt);
    logic [3:0] c;
    nxt = '0;
    while (sh_count > 0) begin
      c = sh_ring[sh_head];
      sh_head = sh_head + 4'd1;
      sh_count--;
      if (sh_valid[c] && sh_state[c] == ST_READY) begin
        nxt = c;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void quantum(ref out_item_t r);
    logic [3:0] nxt;
    logic [3:0] cur;
    cur = sh_cur;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (sh_valid[i] && sh_state[i] == ST_BLOCKED && sh_sleep[i] > 0) begin
        sh_sleep[i] = sh_sleep[i] - 16'd1;
        if (sh_sleep[i] == 0) begin
          sh_state[i] = ST_READY;
          ring_push(4'(i));
        end
      end
    end
    if (sh_valid[cur] && sh_state[cur] == ST_RUNNING) begin
      sh_state[cur] = ST_READY;
      ring_push(cur);
    end
    if (!ring_pick(nxt)) begin
      if (sh_state[cur] != ST_BLOCKED) sh_state[cur] = ST_RUNNING;
      else r.cpu_idle = 1'b1;
      return;
    end
    if (nxt != cur) r.switched = 1'b1;
    sh_cur = nxt;
    sh_state[nxt] = ST_RUNNING;
  endfunction

  function automatic out_item_t sched_event(in_item_t it);
    out_item_t r;
    logic [3:0] t;
    logic [3:0] nxt;
    bit ok_id;
    r = '0;
    t = it.thread_id;
    ok_id = sh_valid[t];
    case (it.action)
      ACT_TICK: quantum(r);
      ACT_CREATE: begin
        r.status = 1'b1;
        for (int i = 0; i < MAX_THREADS; i++) begin
          if (r.status && !sh_valid[i]) begin
            sh_valid[i] = 1'b1;
            sh_state[i] = ST_READY;
            sh_sleep[i] = '0;
            ring_push(4'(i));
            r.new_thread = 4'(i);
            r.status = 1'b0;
          end
        end
      end
      ACT_EXIT: begin
        if (t == 0 || !ok_id) begin
          r.status = 1'b1;
        end else begin
          sh_valid[t] = 1'b0;
          sh_state[t] = ST_BLOCKED;
          sh_sleep[t] = '0;
          if (t == sh_cur) begin
            if (ring_pick(nxt)) begin
              sh_cur = nxt;
              sh_state[nxt] = ST_RUNNING;
              r.switched = 1'b1;
            end else begin
              r.all_done = 1'b1;
            end
          end
        end
      end
      ACT_BLOCK: begin
        if (t == 0 || !ok_id) begin
          r.status = 1'b1;
        end else if (sh_state[t] != ST_BLOCKED) begin
          sh_state[t] = ST_BLOCKED;
          if (t == sh_cur) quantum(r);
        end
      end
      ACT_UNBLOCK: begin
        if (!ok_id) begin
          r.status = 1'b1;
        end else if (sh_state[t] == ST_BLOCKED) begin
          sh_state[t] = ST_READY;
          ring_push(t);
        end
      end
      ACT_SLEEP: begin
        if (it.sleep_count == 0 || sh_cur == 0) begin
          r.status = 1'b1;
        end else begin
          sh_sleep[sh_cur] = it.sleep_count;
          sh_state[sh_cur] = ST_BLOCKED;
          quantum(r);
        end
      end
      default: r.status = 1'b1;
    endcase
    r.running_thread = sh_cur;
    return r;
  endfunction

  // Directed table: a typed expectation is used where has_exp is set.
  typedef struct {
    in_item_t it;
    bit has_exp;
    out_item_t exp;
  } step_t;

  function automatic step_t row(logic [2:0] a, logic [3:0] id, logic [15:0] cnt,
                                bit has_exp = 1'b0, out_item_t e = '0);
    step_t s;
    s.it.action = a;
    s.it.thread_id = id;
    s.it.sleep_count = cnt;
    s.has_exp = has_exp;
    s.exp = e;
    return s;
  endfunction

  // Fields: status, new_thread, running_thread, switched, cpu_idle, all_done.
  step_t directed[$];
  initial begin
    directed = '{
      row(ACT_TICK, 4'd0, 16'd0, 1'b1, '{1'b0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}),
      row(ACT_SLEEP, 4'd0, 16'd5, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}),
      row(ACT_EXIT, 4'd0, 16'd0, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}),
      row(ACT_BLOCK, 4'd0, 16'd0, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}),
      row(ACT_EXIT, 4'd15, 16'd0, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}),
      row(ACT_UNBLOCK, 4'd15, 16'd0, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}),
      row(ACT_UNBLOCK, 4'd0, 16'd0, 1'b1, '{1'b0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}),
      row(ACT_BAD6, 4'd3, 16'hFFFF, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}),
      row(ACT_BAD7, 4'd15, 16'd1, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0}),
      row(ACT_CREATE, 4'd0, 16'd0, 1'b1, '{1'b0, 4'd1, 4'd0, 1'b0, 1'b0, 1'b0}),
      row(ACT_CREATE, 4'd0, 16'd0),
      row(ACT_TICK, 4'd0, 16'd0),
      row(ACT_SLEEP, 4'd0, 16'd0),
      row(ACT_SLEEP, 4'd0, 16'd1),
      row(ACT_TICK, 4'd0, 16'd0),
      row(ACT_SLEEP, 4'd0, 16'hFFFF),
      row(ACT_BLOCK, 4'd2, 16'd0),
      row(ACT_BLOCK, 4'd2, 16'd0),
      row(ACT_UNBLOCK, 4'd2, 16'd0),
      row(ACT_UNBLOCK, 4'd2, 16'd0),
      row(ACT_TICK, 4'd0, 16'd0),
      row(ACT_EXIT, 4'd2, 16'd0),
      row(ACT_EXIT, 4'd1, 16'd0),
      row(ACT_TICK, 4'd0, 16'd0)
    };
  end

  task automatic offer(in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_one(in_item_t it, bit has_exp, out_item_t e);
    out_item_t p;
    p = sched_event(it);
    if (has_exp && p != e) begin
      $error("directed row %0h/%0d: typed expectation %h differs from predictor %h",
             it.action, it.thread_id, e, p);
      errors++;
    end
    pending_results.push_back(has_exp ? e : p);
    offer(it);
  endtask

  function automatic in_item_t random_event();
    in_item_t it;
    int pick;
    int n_live;
    n_live = 0;
    for (int i = 0; i < MAX_THREADS; i++) n_live += sh_valid[i];
    it.sleep_count = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    it.thread_id = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 3) != 0) it.thread_id = sh_cur;
    pick = $urandom_range(0, 99);
    if (pick < 30) it.action = ACT_TICK;
    else if (pick < (n_live < 12 ? 50 : 38)) it.action = ACT_CREATE;
    else if (pick < 58) it.action = ACT_EXIT;
    else if (pick < 70) it.action = ACT_BLOCK;
    else if (pick < 82) it.action = ACT_UNBLOCK;
    else if (pick < 97) it.action = ACT_SLEEP;
    else it.action = ($urandom_range(0, 1) != 0) ? ACT_BAD6 : ACT_BAD7;
    return it;
  endfunction

  // Stimulus
  initial begin
    in_item_t it;
    int gap;
    sched_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[k]) send_one(directed[k].it, directed[k].has_exp, directed[k].exp);
    in_valid <= 1'b0;
    for (int n = 0; n < N_RANDOM;) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      for (int b = $urandom_range(1, 20); b > 0 && n < N_RANDOM; b--, n++) begin
        it = random_event();
        send_one(it, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d scheduler events: %0d results, %0d switches, %0d idle, %0d all-done.",
             directed.size() + N_RANDOM, n_results, n_switch, n_idle, n_done);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Output stall pattern, with one long hold-off part way through.
  initial begin
    int cyc;
    cyc = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (!hold_off_done && n_results >= 100) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off_done = 1'b1;
      end
      if ((cyc / 64) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %h", out_item);
        errors++;
      end else begin
        e = pending_results.pop_front();
        n_results++;
        n_switch += out_item.switched;
        n_idle += out_item.cpu_idle;
        n_done += out_item.all_done;
        if (out_item.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_item.status);
          errors++;
        end
        if (out_item.new_thread !== e.new_thread) begin
          $error("new_thread: expected %0d, got %0d", e.new_thread, out_item.new_thread);
          errors++;
        end
        if (out_item.running_thread !== e.running_thread) begin
          $error("running_thread: expected %0d, got %0d", e.running_thread,
                 out_item.running_thread);
          errors++;
        end
        if (out_item.switched !== e.switched) begin
          $error("switched: expected %0d, got %0d", e.switched, out_item.switched);
          errors++;
        end
        if (out_item.cpu_idle !== e.cpu_idle) begin
          $error("cpu_idle: expected %0d, got %0d", e.cpu_idle, out_item.cpu_idle);
          errors++;
        end
        if (out_item.all_done !== e.all_done) begin
          $error("all_done: expected %0d, got %0d", e.all_done, out_item.all_done);
          errors++;
        end
      end
    end
  end

  // Run limit
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
